// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression that must never be true outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/bfa_pkg.sv -----
// Shared types, constants and helpers of the bitmap frame allocator.
`default_nettype none

package bfa_pkg;

	localparam int WORD_BITS       = 64;
	localparam int WBIT_W          = 6;
	localparam int FRAME_W         = 12;
	localparam int COUNT_W         = 7;
	localparam int STATUS_W        = 3;
	localparam int FREE_W          = 13;
	localparam int DEF_NUM_FRAMES  = 4096;
	localparam int DEF_MAX_REQUEST = 64;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFUSED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;

	typedef enum logic [2:0] {
		CMD_ALLOC,
		CMD_RELEASE,
		CMD_EMPTY,
		CMD_OVERSIZE,
		CMD_BAD_RANGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [COUNT_W-1:0] want;
		logic [FRAME_W-1:0] frame;
	} cmd_t;

	typedef enum logic [1:0] {
		ENG_CLEAR,
		ENG_IDLE,
		ENG_ALLOC,
		ENG_RELEASE
	} eng_state_t;

	// Lowest zero bit of a map word: pick the group of eight, then the bit.
	function automatic logic [WBIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [7:0] grp_free;
		logic [2:0] grp;
		logic [2:0] bit_sel;
		logic [7:0] grp_bits;
		grp_free = '0;
		grp = '0;
		bit_sel = '0;
		for (int g = 0; g < 8; g++) begin
			grp_free[g] = ~&w[g*8 +: 8];
		end
		for (int g = 7; g >= 0; g--) begin
			if (grp_free[g]) begin
				grp = 3'(g);
			end
		end
		grp_bits = w[grp*8 +: 8];
		for (int b = 7; b >= 0; b--) begin
			if (!grp_bits[b]) begin
				bit_sel = 3'(b);
			end
		end
		return {grp, bit_sel};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bfa_queue.sv -----
// Short command queue between the front end and the allocation engine.
`default_nettype none

module bfa_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  bfa_pkg::cmd_t  push_cmd,
	output logic           ready,
	output logic           head_valid,
	output bfa_pkg::cmd_t  head_cmd,
	input  wire            pop
);
	import bfa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready      = count_q != CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && ready) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && ready) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop && head_valid) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			unique case ({push && ready, pop && head_valid})
				2'b10:   count_q <= CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bfa_front.sv -----
// Input stage: takes request words and sorts them into engine commands.
`default_nettype none

module bfa_front #(
	parameter int NUM_FRAMES  = bfa_pkg::DEF_NUM_FRAMES,
	parameter int MAX_REQUEST = bfa_pkg::DEF_MAX_REQUEST
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            hold,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            func,
	input  wire [bfa_pkg::COUNT_W-1:0]     request_count,
	input  wire [bfa_pkg::FRAME_W-1:0]     release_frame,
	output logic                           push,
	output bfa_pkg::cmd_t                  push_cmd,
	input  wire                            q_ready
);
	import bfa_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic take;

	// sort the word into a command; range checks are resolved here
	always_comb begin
		cmd_d.want  = request_count;
		cmd_d.frame = release_frame;
		if (func == FUNC_ALLOC) begin
			if (request_count == '0) begin
				cmd_d.kind = CMD_EMPTY;
			end else if (32'(request_count) > MAX_REQUEST) begin
				cmd_d.kind = CMD_OVERSIZE;
			end else begin
				cmd_d.kind = CMD_ALLOC;
			end
		end else begin
			if (32'(release_frame) >= NUM_FRAMES) begin
				cmd_d.kind = CMD_BAD_RANGE;
			end else begin
				cmd_d.kind = CMD_RELEASE;
			end
		end
	end

	assign push     = valid_s1 && q_ready;
	assign push_cmd = cmd_s1;
	assign in_stall = hold || (valid_s1 && !q_ready);
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bfa_engine.sv -----
// Allocation engine: map memory, free counter, word scan and result register.
`default_nettype none

module bfa_engine #(
	parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES
) (
	input  wire                            clk,
	input  wire                            arst_n,
	output logic                           clearing,
	input  wire                            head_valid,
	input  bfa_pkg::cmd_t                  head_cmd,
	output logic                           pop,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [bfa_pkg::FRAME_W-1:0]    granted_frame,
	output logic [bfa_pkg::STATUS_W-1:0]   status,
	output logic [bfa_pkg::FREE_W-1:0]     remaining_free,
	output logic                           last_result
);
	import bfa_pkg::*;

	localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int FCW   = $clog2(NUM_FRAMES + 1);
	localparam int IW    = AW + WBIT_W;

	logic [WORD_BITS-1:0] mem [WORDS];

	eng_state_t           state_q, state_d;
	logic [AW-1:0]        clr_idx_q;
	logic [AW-1:0]        word_idx_q;
	logic [COUNT_W-1:0]   want_q;
	logic [COUNT_W-1:0]   got_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [WORD_BITS-1:0] work_q;
	logic                 fresh_q;
	logic [WORD_BITS-1:0] rd_word_q;
	logic [FCW-1:0]       free_cnt_q;

	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [WORD_BITS-1:0] wr_data;

	logic                 emit_ok, emit;
	logic [FRAME_W-1:0]   e_frame;
	logic [STATUS_W-1:0]  e_status;
	logic [FCW-1:0]       e_free;
	logic                 e_last;

	logic                 ld_alloc, ld_rel, grant, advance, freed;
	logic [WORD_BITS-1:0] cur, new_word;
	logic [WBIT_W-1:0]    pos;
	logic [IW-1:0]        gidx;
	logic                 last_grant;
	logic [WBIT_W-1:0]    rel_bit;

	assign emit_ok    = !out_valid || !out_stall;
	assign cur        = fresh_q ? rd_word_q : work_q;
	assign pos        = first_zero(cur);
	assign new_word   = cur | (WORD_BITS'(1) << pos);
	assign gidx       = {word_idx_q, pos};
	assign last_grant = COUNT_W'(got_q + 1'b1) == want_q;
	assign rel_bit    = frame_q[WBIT_W-1:0];
	assign clearing   = state_q == ENG_CLEAR;

	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		wr_addr  = word_idx_q;
		wr_data  = cur;
		rd_en    = 1'b0;
		rd_addr  = '0;
		pop      = 1'b0;
		emit     = 1'b0;
		e_frame  = '0;
		e_status = ST_GRANTED;
		e_free   = free_cnt_q;
		e_last   = 1'b1;
		ld_alloc = 1'b0;
		ld_rel   = 1'b0;
		grant    = 1'b0;
		advance  = 1'b0;
		freed    = 1'b0;
		unique case (state_q)
			ENG_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
				if (clr_idx_q == AW'(WORDS - 1)) begin
					state_d = ENG_IDLE;
				end
			end
			ENG_IDLE: begin
				if (head_valid) begin
					unique case (head_cmd.kind)
						CMD_EMPTY: begin
							if (emit_ok) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
								pop      = 1'b1;
							end
						end
						CMD_OVERSIZE: begin
							if (emit_ok) begin
								emit     = 1'b1;
								e_status = ST_REFUSED;
								pop      = 1'b1;
							end
						end
						CMD_BAD_RANGE: begin
							if (emit_ok) begin
								emit     = 1'b1;
								e_status = ST_BAD_RELEASE;
								e_frame  = head_cmd.frame;
								pop      = 1'b1;
							end
						end
						CMD_ALLOC: begin
							if (32'(head_cmd.want) > 32'(free_cnt_q)) begin
								if (emit_ok) begin
									emit     = 1'b1;
									e_status = ST_REFUSED;
									pop      = 1'b1;
								end
							end else begin
								pop      = 1'b1;
								ld_alloc = 1'b1;
								rd_en    = 1'b1;
								rd_addr  = '0;
								state_d  = ENG_ALLOC;
							end
						end
						CMD_RELEASE: begin
							pop     = 1'b1;
							ld_rel  = 1'b1;
							rd_en   = 1'b1;
							rd_addr = AW'(32'(head_cmd.frame) >> WBIT_W);
							state_d = ENG_RELEASE;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ENG_ALLOC: begin
				if (~&cur) begin
					if (emit_ok) begin
						grant    = 1'b1;
						emit     = 1'b1;
						e_status = ST_GRANTED;
						e_frame  = FRAME_W'(gidx);
						e_free   = FCW'(free_cnt_q - 1'b1);
						e_last   = last_grant;
						if (last_grant) begin
							wr_en   = 1'b1;
							wr_data = new_word;
							state_d = ENG_IDLE;
						end
					end
				end else begin
					// word is full: store it and fetch the next one
					advance = 1'b1;
					wr_en   = 1'b1;
					wr_data = cur;
					rd_en   = 1'b1;
					rd_addr = AW'(word_idx_q + 1'b1);
				end
			end
			ENG_RELEASE: begin
				if (emit_ok) begin
					emit    = 1'b1;
					e_frame = frame_q;
					state_d = ENG_IDLE;
					if (rd_word_q[rel_bit]) begin
						freed    = 1'b1;
						e_status = ST_RELEASED;
						e_free   = FCW'(free_cnt_q + 1'b1);
						wr_en    = 1'b1;
						wr_addr  = AW'(32'(frame_q) >> WBIT_W);
						wr_data  = rd_word_q & ~(WORD_BITS'(1) << rel_bit);
					end else begin
						e_status = ST_BAD_RELEASE;
					end
				end
			end
			default: begin
				state_d = ENG_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// per-command working registers
	always_ff @(posedge clk) begin
		if (ld_alloc) begin
			want_q <= head_cmd.want;
		end
		if (ld_rel) begin
			frame_q <= head_cmd.frame;
		end
		if (state_q == ENG_ALLOC && !advance) begin
			work_q <= grant ? new_word : cur;
		end
		if (emit) begin
			granted_frame  <= e_frame;
			status         <= e_status;
			remaining_free <= FREE_W'(e_free);
			last_result    <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ENG_CLEAR;
			clr_idx_q  <= '0;
			word_idx_q <= '0;
			got_q      <= '0;
			fresh_q    <= 1'b0;
			free_cnt_q <= FCW'(NUM_FRAMES);
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ENG_CLEAR) begin
				clr_idx_q <= AW'(clr_idx_q + 1'b1);
			end
			if (ld_alloc) begin
				word_idx_q <= '0;
				got_q      <= '0;
				fresh_q    <= 1'b1;
			end else if (advance) begin
				word_idx_q <= AW'(word_idx_q + 1'b1);
				fresh_q    <= 1'b1;
			end else if (state_q == ENG_ALLOC) begin
				fresh_q <= 1'b0;
			end
			if (grant) begin
				got_q      <= COUNT_W'(got_q + 1'b1);
				free_cnt_q <= FCW'(free_cnt_q - 1'b1);
			end else if (freed) begin
				free_cnt_q <= FCW'(free_cnt_q + 1'b1);
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/bitmap_frame_allocator_unit.sv -----
// Top level of the first-fit bitmap frame allocator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall  | func, request_count, release_frame
//  out     | output    | out_valid / out_stall| granted_frame, status, remaining_free,
//          |           |                      | last_result
//
// Steps: an allocate of n frames first fetches the first map word, then passes over each
// full map word and grants the n frames one at a time, each grant waiting on out_stall;
// the scan runs over the 64-bit map memory; a release reads the word, then writes it
// back; refused or empty requests are answered from the idle state.
// Reset: the map memory is swept to all-free, one word per cycle, with in_stall high.
// Stalls: a two-entry command queue sits between the input stage and the engine,
// so new words keep being taken while the engine waits on out_stall, until the queue fills.
`default_nettype none

module bitmap_frame_allocator_unit #(
	parameter int NUM_FRAMES  = bfa_pkg::DEF_NUM_FRAMES,
	parameter int MAX_REQUEST = bfa_pkg::DEF_MAX_REQUEST
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            func,
	input  wire [bfa_pkg::COUNT_W-1:0]     request_count,
	input  wire [bfa_pkg::FRAME_W-1:0]     release_frame,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [bfa_pkg::FRAME_W-1:0]    granted_frame,
	output logic [bfa_pkg::STATUS_W-1:0]   status,
	output logic [bfa_pkg::FREE_W-1:0]     remaining_free,
	output logic                           last_result
);
	import bfa_pkg::*;

	// front end to queue
	logic push;
	cmd_t push_cmd;
	logic q_ready;

	// queue to engine
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// engine sweeping the map after reset
	logic clearing;

	bfa_front #(
		.NUM_FRAMES  (NUM_FRAMES),
		.MAX_REQUEST (MAX_REQUEST)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold          (clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.request_count (request_count),
		.release_frame (release_frame),
		.push          (push),
		.push_cmd      (push_cmd),
		.q_ready       (q_ready)
	);

	bfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.ready      (q_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// engine owns the map, the free count and the result register
	bfa_engine #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.clearing       (clearing),
		.head_valid     (head_valid),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted_frame  (granted_frame),
		.status         (status),
		.remaining_free (remaining_free),
		.last_result    (last_result)
	);

endmodule

`default_nettype wire

// ----- rtl/bfa_checker.sv -----
// Port-level checks of the frame allocator and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module bfa_checker #(
	parameter int NUM_FRAMES = bfa_pkg::DEF_NUM_FRAMES
) (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            out_valid,
	input wire                            out_stall,
	input wire [bfa_pkg::FRAME_W-1:0]     granted_frame,
	input wire [bfa_pkg::STATUS_W-1:0]    status,
	input wire [bfa_pkg::FREE_W-1:0]      remaining_free,
	input wire                            last_result
);
	import bfa_pkg::*;

	// anything but a grant is a single-word answer
	`ASSERT_CLK(a_single_nongrant, out_valid && status != ST_GRANTED |-> last_result, "non-grant result not marked last")
	// refused and empty answers carry frame zero
	`ASSERT_NEVER(a_zero_frame, out_valid && (status == ST_REFUSED || status == ST_EMPTY) && granted_frame != '0, "refused or empty result with nonzero frame")
	// free count never exceeds the pool
	`ASSERT_NEVER(a_free_bound, out_valid && NUM_FRAMES < 8192 && 32'(remaining_free) > NUM_FRAMES, "free count above frame total")
	// a stalled result word is held
	`ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(granted_frame) && $stable(status) && $stable(remaining_free), "stalled result changed")

endmodule

bind bitmap_frame_allocator_unit bfa_checker #(
	.NUM_FRAMES (NUM_FRAMES)
) u_bfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.granted_frame  (granted_frame),
	.status         (status),
	.remaining_free (remaining_free),
	.last_result    (last_result)
);

`default_nettype wire
